// File: rtl/gcrw_pkg.sv
`timescale 1ns / 1ps
package gcrw_pkg;
    localparam int unsigned FracOne = 65536;
    localparam logic [31:0] StillStep = 32'h0100_0000;

    // Datapath commands from the controller.
    typedef struct packed {
        logic load;      // capture inputs and run the fixed setup
        logic div_start; // start one divide (sel chooses the axis)
        logic div_sel;   // 0: y step, 1: x step
        logic fin_x;     // form the x intercept
        logic fin_y;     // form the y intercept
        logic walk;      // advance one cell
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic at_end;
    } dp_stat_t;
endpackage

// File: rtl/grid_cell_ray_walk.sv
`timescale 1ns / 1ps
// Order: the first cell word is offered after a segment is accepted, once two serial
// divides and then the two intercept steps (x, then y) have run.
// Throughput: one result word per cycle while m_tready is high; s_tready returns
// in the cycle after the last cell word is taken.
// Reset: aresetn, synchronous and active low, clears the controller and origins.
module grid_cell_ray_walk #(
    parameter int unsigned MAX_STEPS  = 64,
    parameter int unsigned CELL_SHIFT = 23
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // start_x, start_y, end_x, end_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // cell_x, cell_y, reached_end, zero fill
    output logic         m_tlast,   // last_cell
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    logic signed [31:0] origin_x_reg, origin_y_reg;
    gcrw_pkg::dp_cmd_t  cmd;
    gcrw_pkg::dp_stat_t stat;
    logic [8:0] cell_x, cell_y;
    logic reached_end;

    // Origins must only be written while the walker is idle; the block itself does not enforce this.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index) origin_y_reg <= cfg_data;
            else origin_x_reg <= cfg_data;
        end
    end

    gcrw_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_tvalid && s_tready),
        .in_ready(s_tready), .cmd(cmd), .stat(stat), .out_valid(m_tvalid),
        .out_ready(m_tready), .last_cell(m_tlast), .reached_end(reached_end)
    );

    gcrw_datapath #(.CELL_SHIFT(CELL_SHIFT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .origin_x(origin_x_reg), .origin_y(origin_y_reg), .in_data(s_tdata),
        .cell_x(cell_x), .cell_y(cell_y)
    );

    assign m_tdata = {5'd0, reached_end, cell_y, cell_x};
endmodule

// File: rtl/gcrw_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider: quotient of (|a| << 16) / b, one bit a cycle.
module gcrw_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic [47:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[31:0], q_reg[47]} - {1'b0, divisor};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 6'd47;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                r_next = trial;
                q_next = {q_reg[46:0], 1'b1};
            end else begin
                r_next = {r_reg[31:0], q_reg[47]};
                q_next = {q_reg[46:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule

// File: rtl/gcrw_datapath.sv
`timescale 1ns / 1ps
module gcrw_datapath #(
    parameter int unsigned CELL_SHIFT = 23
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gcrw_pkg::dp_cmd_t   cmd,
    output gcrw_pkg::dp_stat_t  stat,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic [127:0]        in_data,
    output logic [8:0]          cell_x,
    output logic [8:0]          cell_y
);
    localparam int unsigned CellW = 32 - CELL_SHIFT;
    // The walk can move up to MAX_STEPS - 1 cells (63 by default) past the start, so the position
    // counters carry headroom beyond the cell index width.
    localparam int unsigned WalkW = CellW + 7;
    localparam int unsigned FracSh = CELL_SHIFT - 16;
    localparam logic [31:0] CMask = (32'd1 << CELL_SHIFT) - 32'd1;

    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [31:0] xs_reg, ys_reg, xi_reg, yi_reg;
    logic signed [WalkW-1:0] mx_reg, my_reg;
    logic signed [CellW-1:0] xt2_reg, yt2_reg;
    logic [1:0] mxs_reg, mys_reg; // {move, negative}
    logic [16:0] px_reg, py_reg;

    logic signed [31:0] sx, sy, rx1, ry1, rx2, ry2;
    logic signed [CellW-1:0] xt1, yt1, xt2, yt2;
    logic [15:0] frx, fry;

    always_comb begin
        sx = in_data[31:0];
        sy = in_data[63:32];
        if (((sx - origin_x) & CMask) == '0) sx = sx + 32'sd65536;
        if (((sy - origin_y) & CMask) == '0) sy = sy + 32'sd65536;
        rx1 = sx - origin_x;
        ry1 = sy - origin_y;
        rx2 = $signed(in_data[95:64]) - origin_x;
        ry2 = $signed(in_data[127:96]) - origin_y;
        xt1 = rx1[31:CELL_SHIFT];
        yt1 = ry1[31:CELL_SHIFT];
        xt2 = rx2[31:CELL_SHIFT];
        yt2 = ry2[31:CELL_SHIFT];
        frx = rx1[FracSh+15:FracSh];
        fry = ry1[FracSh+15:FracSh];
    end

    // Divide: other-axis delta over |own-axis delta|, saturating.
    logic signed [31:0] num, den_s;
    logic [31:0] den, anum;
    logic [47:0] q;
    logic div_done, sat_reg, neg_reg;
    logic [31:0] step_res;

    always_comb begin
        num = cmd.div_sel ? (x2_reg - x1_reg) : (y2_reg - y1_reg);
        den_s = cmd.div_sel ? (y2_reg - y1_reg) : (x2_reg - x1_reg);
        den = den_s[31] ? 32'(-den_s) : 32'(den_s);
        anum = num[31] ? 32'(-num) : 32'(num);
    end

    logic sel_reg;
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            sat_reg <= ({14'd0, anum[31:14]} >= den);
            neg_reg <= num[31];
            sel_reg <= cmd.div_sel;
        end
    end

    gcrw_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend({anum, 16'd0}), .divisor(den), .done(div_done), .quotient(q)
    );

    always_comb begin
        if (sat_reg) step_res = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else step_res = neg_reg ? 32'(-q[31:0]) : q[31:0];
    end

    // Intercept = (start >> FracSh) + ((partial * step) >> 16).
    logic signed [31:0] fin_step, fin_base;
    logic [16:0] fin_part;
    logic signed [49:0] prod;
    always_comb begin
        fin_step = cmd.fin_x ? xs_reg : ys_reg;
        fin_part = cmd.fin_x ? py_reg : px_reg;
        fin_base = cmd.fin_x ? (x1_reg >>> FracSh) : (y1_reg >>> FracSh);
        prod = $signed({1'b0, fin_part}) * fin_step;
    end

    logic ya, xa;
    always_comb begin
        xa = (32'($signed(xi_reg[31:16])) == 32'(mx_reg));
        ya = (32'($signed(yi_reg[31:16])) == 32'(my_reg));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x1_reg <= rx1; y1_reg <= ry1; x2_reg <= rx2; y2_reg <= ry2;
            mx_reg <= WalkW'(xt1); my_reg <= WalkW'(yt1);
            xt2_reg <= xt2; yt2_reg <= yt2;
            if (xt2 > xt1) begin
                mxs_reg <= 2'b10; px_reg <= 17'(gcrw_pkg::FracOne) - {1'b0, frx};
            end else if (xt2 < xt1) begin
                mxs_reg <= 2'b11; px_reg <= {1'b0, frx};
            end else begin
                mxs_reg <= 2'b00; px_reg <= 17'(gcrw_pkg::FracOne);
            end
            if (yt2 > yt1) begin
                mys_reg <= 2'b10; py_reg <= 17'(gcrw_pkg::FracOne) - {1'b0, fry};
            end else if (yt2 < yt1) begin
                mys_reg <= 2'b11; py_reg <= {1'b0, fry};
            end else begin
                mys_reg <= 2'b00; py_reg <= 17'(gcrw_pkg::FracOne);
            end
            xs_reg <= gcrw_pkg::StillStep;
            ys_reg <= gcrw_pkg::StillStep;
        end
        if (div_done) begin
            if (sel_reg) begin
                if (mys_reg[1]) xs_reg <= step_res;
            end else begin
                if (mxs_reg[1]) ys_reg <= step_res;
            end
        end
        if (cmd.fin_x) xi_reg <= fin_base + prod[47:16];
        if (cmd.fin_y) yi_reg <= fin_base + prod[47:16];
        if (cmd.walk) begin
            if (ya) begin
                yi_reg <= yi_reg + ys_reg;
                if (mxs_reg[1]) begin
                    mx_reg <= mxs_reg[0] ? mx_reg - WalkW'(1) : mx_reg + WalkW'(1);
                end
            end else if (xa) begin
                xi_reg <= xi_reg + xs_reg;
                if (mys_reg[1]) begin
                    my_reg <= mys_reg[0] ? my_reg - WalkW'(1) : my_reg + WalkW'(1);
                end
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.at_end = (32'(mx_reg) == 32'(xt2_reg)) && (32'(my_reg) == 32'(yt2_reg));
    assign cell_x = 9'(mx_reg);
    assign cell_y = 9'(my_reg);
endmodule

// File: rtl/gcrw_ctrl.sv
`timescale 1ns / 1ps
module gcrw_ctrl #(
    parameter int unsigned MAX_STEPS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    output logic               in_ready,
    output gcrw_pkg::dp_cmd_t  cmd,
    input  gcrw_pkg::dp_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               last_cell,
    output logic               reached_end
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIVY, S_DIVX, S_FIN, S_EMIT
    } state_t;

    localparam int unsigned CntW = $clog2(MAX_STEPS + 1);

    state_t state_reg;
    logic [CntW-1:0] n_reg;
    logic started_reg;
    logic last_now;

    assign last_now = stat.at_end || (n_reg == CntW'(MAX_STEPS - 1));

    // fin_x and fin_y share one multiplier: fin_x first, then fin_y.
    always_comb begin
        cmd = '0;
        cmd.load = in_fire;
        cmd.div_start = (state_reg == S_DIVY || state_reg == S_DIVX) && !started_reg;
        cmd.div_sel = (state_reg == S_DIVX);
        cmd.fin_x = (state_reg == S_FIN) && !started_reg;
        cmd.fin_y = (state_reg == S_FIN) && started_reg;
        cmd.walk = (state_reg == S_EMIT) && out_ready && !last_now;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign last_cell = last_now;
    assign reached_end = stat.at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg <= '0;
            started_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    started_reg <= 1'b0;
                    n_reg <= '0;
                    if (in_fire) state_reg <= S_DIVY;
                end
                S_DIVY, S_DIVX: begin
                    started_reg <= 1'b1;
                    if (stat.div_done) begin
                        started_reg <= 1'b0;
                        state_reg <= (state_reg == S_DIVY) ? S_DIVX : S_FIN;
                    end
                end
                S_FIN: begin
                    started_reg <= 1'b1;
                    if (started_reg) begin
                        started_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_ready) begin
                        n_reg <= n_reg + CntW'(1);
                        if (last_now) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/gcrw_checker.sv
`timescale 1ns / 1ps
module gcrw_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tlast,
    input logic [23:0]  m_tdata
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during output");
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tlast) else $error("end without last");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid) else $error("beat after last");
endmodule

bind grid_cell_ray_walk gcrw_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tdata(m_tdata)
);
